>>> hdl/moving_average_crossover_signal_core_assert.svh
// Assertion macros for the crossover core.
`ifndef MOVING_AVERAGE_CROSSOVER_SIGNAL_CORE_ASSERT_SVH
`define MOVING_AVERAGE_CROSSOVER_SIGNAL_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MACS_ASSERT_SAME(lbl, clock, rst_n, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed (same cycle)");
`define MACS_ASSERT_NEXT(lbl, clock, rst_n, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed (next cycle)");
`else
`define MACS_ASSERT_SAME(lbl, clock, rst_n, ante, cons)
`define MACS_ASSERT_NEXT(lbl, clock, rst_n, ante, cons)
`endif

`endif

>>> hdl/macs_pkg.sv
`default_nettype none

package macs_pkg;

	localparam int DEPTH   = 256;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int PRICE_W = 32;
	localparam int TIME_W  = 63;
	localparam int LEN_W   = 9;
	localparam int QTY_W   = 32;
	localparam int ID_W    = 32;
	localparam int DATA_W  = 32;
	localparam int SUM_W   = PRICE_W + IDX_W;
	localparam int PROD_W  = SUM_W + CNT_W;

	localparam logic [LEN_W-1:0] FAST_LEN_RST = LEN_W'(10);
	localparam logic [LEN_W-1:0] SLOW_LEN_RST = LEN_W'(30);
	localparam logic [QTY_W-1:0] QTY_RST      = QTY_W'(100);
	localparam logic [ID_W-1:0]  ID_FIRST     = ID_W'(1);
	localparam logic [ID_W-1:0]  ID_LAST      = '1;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef enum logic [1:0] {
		REG_FAST_LENGTH    = 2'd0,
		REG_SLOW_LENGTH    = 2'd1,
		REG_ORDER_QUANTITY = 2'd2
	} cfg_reg_t;

	// zero counts as one bar, anything beyond the ring as the full ring
	function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (32'(v) > 32'(DEPTH)) begin
			r = CNT_W'(DEPTH);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/moving_average_crossover_signal_core.sv
// Dual simple moving average crossover. Takes one price bar per cycle and
// emits a buy order when the fast average rises above the slow one with no
// position held, and a sell order when it falls below with a position held.
// Window sums come from a ring of running cumulative sums (one write and two
// reads per bar), so a length change applies from the next bar with no
// recomputation. Throughput is one bar per cycle; an order passes from its bar
// through the ring read, the cross products and the result register in turn.
// Bars stall only when the output register holds a stalled order, stage 2
// holds a further order and stage 1 is occupied. Configuration is written
// through a port that is always ready.
`default_nettype none

module moving_average_crossover_signal_core
	import macs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                bar_valid,
	output      logic                bar_stall,
	input  wire logic [PRICE_W-1:0]  close_price,
	input  wire logic [TIME_W-1:0]   bar_timestamp,

	output      logic                order_valid,
	input  wire logic                order_stall,
	output      logic                order_side,
	output      logic [ID_W-1:0]     order_id,
	output      logic [PRICE_W-1:0]  order_price,
	output      logic [QTY_W-1:0]    order_quantity,
	output      logic [TIME_W-1:0]   order_time,

	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [DATA_W-1:0]   cfg_data
);

	logic [LEN_W-1:0]   fast_len_q;
	logic [LEN_W-1:0]   slow_len_q;
	logic [QTY_W-1:0]   qty_q;

	logic [IDX_W-1:0]   wr_idx_q;
	logic [CNT_W-1:0]   samples_q;
	logic [SUM_W-1:0]   cum_q;
	logic               holding_q;
	logic [ID_W-1:0]    next_id_q;

	logic [SUM_W-1:0]   hist_mem [DEPTH];

	logic               accept;
	logic [CNT_W-1:0]   samples_new;
	logic [CNT_W-1:0]   fl_eff;
	logic [CNT_W-1:0]   sl_eff;
	logic [CNT_W-1:0]   fc;
	logic [CNT_W-1:0]   sc;
	logic [IDX_W-1:0]   f_addr;
	logic [IDX_W-1:0]   s_addr;
	logic [SUM_W-1:0]   cum_new;

	logic               v_s1;
	logic [SUM_W-1:0]   cum_s1;
	logic [SUM_W-1:0]   fbase_rd_s1;
	logic [SUM_W-1:0]   sbase_rd_s1;
	logic               fzero_s1;
	logic               szero_s1;
	logic [CNT_W-1:0]   fc_s1;
	logic [CNT_W-1:0]   sc_s1;
	logic               ok_s1;
	logic [PRICE_W-1:0] price_s1;
	logic [TIME_W-1:0]  time_s1;

	logic [SUM_W-1:0]   fsum;
	logic [SUM_W-1:0]   ssum;

	logic               v_s2;
	logic [PROD_W-1:0]  fprod_s2;
	logic [PROD_W-1:0]  sprod_s2;
	logic               ok_s2;
	logic [PRICE_W-1:0] price_s2;
	logic [TIME_W-1:0]  time_s2;

	logic               out_free;
	logic               emit;
	logic               retire;
	logic               s2_ready;
	logic               s1_ready;
	logic               adv_s1;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_len_q <= FAST_LEN_RST;
			slow_len_q <= SLOW_LEN_RST;
			qty_q      <= QTY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FAST_LENGTH:    fast_len_q <= cfg_data[LEN_W-1:0];
				REG_SLOW_LENGTH:    slow_len_q <= cfg_data[LEN_W-1:0];
				REG_ORDER_QUANTITY: qty_q      <= cfg_data[QTY_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign out_free  = !order_valid || !order_stall;
	assign s2_ready  = !v_s2 || retire;
	assign s1_ready  = !v_s1 || s2_ready;
	assign adv_s1    = v_s1 && s2_ready;
	assign bar_stall = !s1_ready;
	assign accept    = bar_valid && !bar_stall;

	// intake
	always_comb begin
		samples_new = (samples_q == CNT_W'(DEPTH)) ? samples_q : samples_q + CNT_W'(1);
		fl_eff      = eff_len(fast_len_q);
		sl_eff      = eff_len(slow_len_q);
		fc          = (samples_new < fl_eff) ? samples_new : fl_eff;
		sc          = (samples_new < sl_eff) ? samples_new : sl_eff;
		f_addr      = wr_idx_q - fc[IDX_W-1:0];
		s_addr      = wr_idx_q - sc[IDX_W-1:0];
		cum_new     = cum_q + SUM_W'(close_price);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			samples_q <= '0;
			cum_q     <= '0;
		end else if (accept) begin
			wr_idx_q  <= wr_idx_q + IDX_W'(1);
			samples_q <= samples_new;
			cum_q     <= cum_new;
		end
	end

	// ring of cumulative sums, read before write at the same slot
	always_ff @(posedge clk) begin
		if (accept) begin
			hist_mem[wr_idx_q] <= cum_new;
			fbase_rd_s1        <= hist_mem[f_addr];
			sbase_rd_s1        <= hist_mem[s_addr];
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ready) begin
			v_s1 <= bar_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cum_s1   <= cum_new;
			// window reaches back to before the first bar
			fzero_s1 <= (samples_q != CNT_W'(DEPTH)) && (fc == samples_new);
			szero_s1 <= (samples_q != CNT_W'(DEPTH)) && (sc == samples_new);
			fc_s1    <= fc;
			sc_s1    <= sc;
			ok_s1    <= samples_new >= sl_eff;
			price_s1 <= close_price;
			time_s1  <= bar_timestamp;
		end
	end

	assign fsum = cum_s1 - (fzero_s1 ? '0 : fbase_rd_s1);
	assign ssum = cum_s1 - (szero_s1 ? '0 : sbase_rd_s1);

	// stage 2: cross products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fprod_s2 <= PROD_W'(fsum) * PROD_W'(sc_s1);
			sprod_s2 <= PROD_W'(ssum) * PROD_W'(fc_s1);
			ok_s2    <= ok_s1;
			price_s2 <= price_s1;
			time_s2  <= time_s1;
		end
	end

	// decision
	assign emit   = v_s2 && ok_s2 && (((fprod_s2 > sprod_s2) && !holding_q) ||
		((fprod_s2 < sprod_s2) && holding_q));
	assign retire = v_s2 && (!emit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
			next_id_q <= ID_FIRST;
		end else if (retire && emit) begin
			holding_q <= !holding_q;
			next_id_q <= (next_id_q == ID_LAST) ? ID_FIRST : next_id_q + ID_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_valid <= 1'b0;
		end else if (retire && emit) begin
			order_valid <= 1'b1;
		end else if (!order_stall) begin
			order_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && emit) begin
			order_side     <= holding_q ? SIDE_SELL : SIDE_BUY;
			order_id       <= next_id_q;
			order_price    <= price_s2;
			order_quantity <= qty_q;
			order_time     <= time_s2;
		end
	end

	`include "moving_average_crossover_signal_core_assert.svh"

	`MACS_ASSERT_NEXT(a_side_tracks_position, clk, arst_n, retire && emit,
		holding_q == (order_side == SIDE_BUY))
	`MACS_ASSERT_NEXT(a_id_never_zero, clk, arst_n, retire && emit, next_id_q != '0)
	`MACS_ASSERT_SAME(a_stall_needs_full_s1, clk, arst_n, bar_stall, v_s1 && v_s2)

endmodule

`default_nettype wire

>>> tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import macs_pkg::*;

	localparam logic [1:0] REG_UNUSED    = 2'd3;
	localparam int         CYCLE_LIMIT   = 200000;
	localparam int         LATENCY_SLACK = 8;
	localparam int         DRAIN_LIMIT   = 2000;
	localparam longint     PRICE_TOP     = (longint'(1) << PRICE_W) - 1;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [TIME_W-1:0]  stamp;
	} bar_t;

	typedef struct packed {
		logic               side;
		logic [ID_W-1:0]    id;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
		logic [TIME_W-1:0]  stamp;
	} order_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               bar_valid = 1'b0;
	logic               bar_stall;
	logic [PRICE_W-1:0] close_price = '0;
	logic [TIME_W-1:0]  bar_timestamp = '0;

	logic               order_valid;
	logic               order_stall = 1'b0;
	logic               order_side;
	logic [ID_W-1:0]    order_id;
	logic [PRICE_W-1:0] order_price;
	logic [QTY_W-1:0]   order_quantity;
	logic [TIME_W-1:0]  order_time;

	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = REG_FAST_LENGTH;
	logic [DATA_W-1:0]  cfg_data = '0;

	// predictor state
	logic [PRICE_W-1:0] price_ring [DEPTH];
	logic [IDX_W-1:0]   ring_wr = '0;
	int unsigned        bars_seen = 0;
	logic               in_position = 1'b0;
	logic [ID_W-1:0]    id_next = ID_FIRST;
	logic [LEN_W-1:0]   fast_len = FAST_LEN_RST;
	logic [LEN_W-1:0]   slow_len = SLOW_LEN_RST;
	logic [QTY_W-1:0]   order_qty = QTY_RST;

	bar_t   pending_bars [$];
	order_t due_orders [$];
	int     bars_queued = 0;
	int     bars_accepted = 0;
	int     error_count = 0;
	int     cycle_count = 0;
	int     send_gap_pct = 0;
	int     recv_stall_pct = 0;

	moving_average_crossover_signal_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.bar_valid      (bar_valid),
		.bar_stall      (bar_stall),
		.close_price    (close_price),
		.bar_timestamp  (bar_timestamp),
		.order_valid    (order_valid),
		.order_stall    (order_stall),
		.order_side     (order_side),
		.order_id       (order_id),
		.order_price    (order_price),
		.order_quantity (order_quantity),
		.order_time     (order_time),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int unsigned window_bars(input logic [LEN_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > DEPTH)
			return DEPTH;
		return 32'(v);
	endfunction

	function automatic void predict_order(input logic [PRICE_W-1:0] price,
			input logic [TIME_W-1:0] stamp);
		int unsigned fl, sl, fc, sc, span;
		logic [63:0] fast_sum, slow_sum, fast_side, slow_side;
		logic [PRICE_W-1:0] p;
		order_t o;
		price_ring[ring_wr] = price;
		ring_wr = ring_wr + IDX_W'(1);
		if (bars_seen < DEPTH)
			bars_seen++;
		fl = window_bars(fast_len);
		sl = window_bars(slow_len);
		fc = (bars_seen < fl) ? bars_seen : fl;
		sc = (bars_seen < sl) ? bars_seen : sl;
		span = (fc > sc) ? fc : sc;
		fast_sum = '0;
		slow_sum = '0;
		for (int unsigned k = 1; k <= span; k++) begin
			p = price_ring[IDX_W'(ring_wr - k)];
			if (k <= fc)
				fast_sum += 64'(p);
			if (k <= sc)
				slow_sum += 64'(p);
		end
		if (bars_seen < sl)
			return;
		// averages compared without division
		fast_side = fast_sum * 64'(sc);
		slow_side = slow_sum * 64'(fc);
		if (fast_side > slow_side && !in_position) begin
			o.side = SIDE_BUY;
		end else if (fast_side < slow_side && in_position) begin
			o.side = SIDE_SELL;
		end else begin
			return;
		end
		o.id = id_next;
		o.price = price;
		o.qty = order_qty;
		o.stamp = stamp;
		due_orders.insert(due_orders.size(), o);
		in_position = (o.side == SIDE_BUY);
		id_next = (id_next == ID_LAST) ? ID_FIRST : id_next + ID_W'(1);
	endfunction

	// bar driver
	always @(posedge clk) begin
		bar_t nxt;
		if (arst_n) begin
			if (bar_valid && !bar_stall) begin
				predict_order(close_price, bar_timestamp);
				bars_accepted++;
			end
			if (!bar_valid || !bar_stall) begin
				if (pending_bars.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					nxt = pending_bars[0];
					pending_bars.delete(0);
					bar_valid <= 1'b1;
					close_price <= nxt.price;
					bar_timestamp <= nxt.stamp;
				end else begin
					bar_valid <= 1'b0;
				end
			end
		end
	end

	// order monitor
	always @(posedge clk) begin
		order_t want;
		if (arst_n) begin
			if (order_valid && !order_stall) begin
				if (due_orders.size() == 0) begin
					report_error($sformatf("order id %0d with none outstanding", order_id));
				end else begin
					want = due_orders[0];
					due_orders.delete(0);
					if (order_side !== want.side)
						report_error($sformatf("id %0d side %0b, want %0b",
							want.id, order_side, want.side));
					if (order_id !== want.id)
						report_error($sformatf("order id %0d, want %0d", order_id, want.id));
					if (order_price !== want.price)
						report_error($sformatf("id %0d price %0h, want %0h",
							want.id, order_price, want.price));
					if (order_quantity !== want.qty)
						report_error($sformatf("id %0d quantity %0h, want %0h",
							want.id, order_quantity, want.qty));
					if (order_time !== want.stamp)
						report_error($sformatf("id %0d time %0h, want %0h",
							want.id, order_time, want.stamp));
				end
			end
			order_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic logic [TIME_W-1:0] rand_stamp();
		return TIME_W'({$urandom, $urandom});
	endfunction

	function automatic void queue_bar(input logic [PRICE_W-1:0] price,
			input logic [TIME_W-1:0] stamp);
		bar_t b;
		b.price = price;
		b.stamp = stamp;
		pending_bars.insert(pending_bars.size(), b);
		bars_queued++;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FAST_LENGTH:    fast_len = data[LEN_W-1:0];
			REG_SLOW_LENGTH:    slow_len = data[LEN_W-1:0];
			REG_ORDER_QUANTITY: order_qty = data[QTY_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// sender holds off until every outstanding order has come back or the drain limit runs out
	task automatic wait_orders_done();
		int waited;
		waited = 0;
		while (bars_accepted != bars_queued)
			@(posedge clk);
		while (due_orders.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (due_orders.size() != 0) begin
			report_error($sformatf("%0d orders never arrived", due_orders.size()));
			due_orders.delete();
		end
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	// trending segments so the averages cross, with some noise bars
	task automatic queue_walk(input int count);
		longint lvl, slope;
		int seg, scale, i;
		lvl = $urandom;
		while (count > 0) begin
			if ($urandom_range(99) < 12) begin
				queue_bar($urandom, rand_stamp());
				count--;
			end else begin
				seg = $urandom_range(4, 40);
				scale = ($urandom_range(9) == 0) ? (1 << 24) : $urandom_range(1, 5000);
				slope = longint'($urandom_range(2 * scale)) - scale;
				for (i = 0; i < seg && count > 0; i++) begin
					lvl += slope + longint'($urandom_range(scale / 2)) - scale / 4;
					if (lvl < 0)
						lvl = 0;
					if (lvl > PRICE_TOP)
						lvl = PRICE_TOP;
					queue_bar(PRICE_W'(lvl), rand_stamp());
					count--;
				end
			end
		end
	endtask

	task automatic random_phase(input logic [DATA_W-1:0] fl, input logic [DATA_W-1:0] sl,
			input logic [DATA_W-1:0] qty, input int count);
		write_reg(REG_FAST_LENGTH, fl);
		write_reg(REG_SLOW_LENGTH, sl);
		write_reg(REG_ORDER_QUANTITY, qty);
		queue_walk(count);
		wait_orders_done();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 33;
		recv_stall_pct = 45;

		// reset settings: slow window not yet full, field extremes into history
		queue_bar('0, '0);
		queue_bar('1, '1);
		queue_bar('0, rand_stamp());
		queue_bar('1, rand_stamp());
		queue_bar(1, rand_stamp());
		queue_bar(32'h8000_0000, rand_stamp());
		wait_orders_done();

		// one-bar against two-bar average: buy, equal, sell, equal
		write_reg(REG_FAST_LENGTH, 1);
		write_reg(REG_SLOW_LENGTH, 2);
		write_reg(REG_ORDER_QUANTITY, '1);
		queue_bar('0, rand_stamp());
		queue_bar('1, rand_stamp());
		queue_bar('1, '1);
		queue_bar('0, '0);
		queue_bar('0, rand_stamp());
		wait_orders_done();

		// zero length counts as one bar
		write_reg(REG_FAST_LENGTH, 0);
		write_reg(REG_SLOW_LENGTH, 3);
		write_reg(REG_ORDER_QUANTITY, 0);
		queue_bar(32'h7FFF_FFFF, rand_stamp());
		queue_bar('1, rand_stamp());
		queue_bar(1, rand_stamp());
		queue_bar(2, rand_stamp());
		wait_orders_done();

		// unknown index ignored; oversize length clipped; slow shorter than fast
		write_reg(REG_UNUSED, '1);
		write_reg(REG_FAST_LENGTH, '1);
		write_reg(REG_SLOW_LENGTH, 2);
		queue_bar('1, rand_stamp());
		queue_bar('1, rand_stamp());
		queue_bar('0, rand_stamp());
		queue_bar('0, rand_stamp());
		wait_orders_done();

		random_phase(10, 30, 100, 200);
		random_phase($urandom_range(2, 6), $urandom_range(7, 20), $urandom, 200);

		send_gap_pct = 45;
		recv_stall_pct = 33;
		random_phase(20, 256, $urandom, 200);
		random_phase(0, 511, 1, 150);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		random_phase(12, 5, $urandom, 200);
		random_phase(2, 40, $urandom, 150);
		random_phase(32'hFFFF_FE07, 21, '1, 130);

		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
